[hdl/bab_pkg.sv]
// ----------------------------------------------------------------------------
// bab_pkg: shared definitions for the block allocation bitmap
// Command codes, sequencer types, sizing defaults and the bit-search helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bab_pkg;

    // Default map size in blocks
    localparam int unsigned MAX_BLOCKS_DEF = 1024;

    // Map word width (bits per memory word)
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BIT_SEL_W = 5;

    // Field widths fixed by the interface
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned START_W = 10;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned BIU_W   = 11;
    localparam int unsigned IN_W    = 24;
    localparam int unsigned OUT_W   = 16;

    // Reset value of the blocks-in-use register
    localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_FIND    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MARK    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TEST    = 3'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // What a scan does with each map word
    typedef enum logic [1:0] {
        MODE_FIND,
        MODE_CHECK,
        MODE_SET,
        MODE_CLR
    } t_mode;

    // Position of the lowest set bit (0 when none is set)
    function automatic logic [BIT_SEL_W-1:0] first_one(input logic [WORD_W-1:0] v);
        logic [BIT_SEL_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = BIT_SEL_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

[hdl/block_allocation_bitmap.sv]
// An item that needs no map access goes from acceptance straight to the result
//   state; an item that touches map words first reads and evaluates each of them.
// One item at a time: no request is taken until the last result has gone to the
//   output register; find scans up to 32 words (1024 blocks) through the one-word-per-cycle map RAM port.
// Reset: synchronous; the map RAM is then cleared one word a cycle, ceil(MAX_BLOCKS/32)
//   words in all, with no item accepted (config writes still taken).
// ----------------------------------------------------------------------------
// block_allocation_bitmap
// Used/free bitmap allocator: find, mark, release, check-run and test
// commands over a word-organized map RAM with read-modify-write scanning.
// ----------------------------------------------------------------------------
`default_nettype none

module block_allocation_bitmap
    import bab_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration: blocks_in_use
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [BIU_W-1:0]   i_cfg_data,
    // request stream
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [IN_W-1:0]    i_s_tdata,   // cmd[2:0], start_block[12:3], block_count[23:13]
    // result stream
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [OUT_W-1:0]        o_m_tdata    // answer_flag[0], block_index[10:1],
                                                 // range_error[11], zero[15:12]
);

    localparam int unsigned WORDS   = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int unsigned AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned LIM_W   = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned W       = (LIM_W > 12) ? LIM_W : 12;
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
    localparam logic [W-1:0]  MAX_W     = W'(MAX_BLOCKS);

    // Map RAM
    logic [WORD_W-1:0] r_map [WORDS];
    logic [WORD_W-1:0] r_rd_data;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              rd_en;

    // Control and working registers
    t_state               r_state, n_state;
    t_mode                r_mode, n_mode;
    logic [BIU_W-1:0]     r_biu, n_biu;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic [AW-1:0]        r_rd_addr, n_rd_addr;
    logic [AW-1:0]        r_eval_addr, n_eval_addr;
    logic                 r_issue, n_issue;
    logic                 r_eval, n_eval;
    logic [AW-1:0]        r_ws, n_ws;
    logic [AW-1:0]        r_we, n_we;
    logic [BIT_SEL_W-1:0] r_lo_bit, n_lo_bit;
    logic [BIT_SEL_W-1:0] r_hi_bit, n_hi_bit;
    logic                 r_res_flag, n_res_flag;
    logic [START_W-1:0]   r_res_index, n_res_index;
    logic                 r_res_err, n_res_err;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_W-1:0]     r_out_data, n_out_data;

    // Request decode
    logic [CMD_W-1:0]   in_cmd;
    logic [START_W-1:0] in_start_raw;
    logic [W-1:0]       in_start;
    logic [W-1:0]       in_count;
    logic [W-1:0]       limit;
    logic [W-1:0]       run_end;
    logic [W-1:0]       rel_end;
    logic [W-1:0]       scan_end;
    logic [W-1:0]       end_m1;
    logic               bad;
    logic               in_acc;

    assign in_cmd       = i_s_tdata[2:0];
    assign in_start_raw = i_s_tdata[12:3];
    assign in_start     = W'(in_start_raw);
    assign in_count     = W'(i_s_tdata[23:13]);
    assign limit        = (W'(r_biu) > MAX_W) ? MAX_W : W'(r_biu);
    assign bad          = (in_start >= limit);
    assign run_end      = in_start + in_count;
    assign rel_end      = (run_end > limit) ? limit : run_end;

    // End of the scan (one past its last block), per command
    always_comb begin
        case (in_cmd)
            CMD_FIND:    scan_end = limit;
            CMD_RELEASE: scan_end = rel_end;
            CMD_CHECK:   scan_end = run_end;
            default:     scan_end = in_start + W'(1);
        endcase
    end
    assign end_m1 = scan_end - W'(1);

    assign in_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Word evaluation: masks of blocks inside the run
    logic [WORD_W-1:0]    lo_mask, hi_mask, run_mask, free_hits, used_hits;
    logic [BIT_SEL_W-1:0] hit_pos;
    logic                 last_word;

    assign lo_mask   = (r_eval_addr == r_ws) ? ({WORD_W{1'b1}} << r_lo_bit) : {WORD_W{1'b1}};
    assign hi_mask   = (r_eval_addr == r_we)
                     ? ({WORD_W{1'b1}} >> (BIT_SEL_W'(WORD_W - 1) - r_hi_bit))
                     : {WORD_W{1'b1}};
    assign run_mask  = lo_mask & hi_mask;
    assign free_hits = ~r_rd_data & run_mask;
    assign used_hits = r_rd_data & run_mask;
    assign hit_pos   = first_one(free_hits);
    assign last_word = (r_eval_addr == r_we);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_biu       = r_biu;
        n_clr_addr  = r_clr_addr;
        n_rd_addr   = r_rd_addr;
        n_eval_addr = r_eval_addr;
        n_issue     = r_issue;
        n_eval      = 1'b0;
        n_ws        = r_ws;
        n_we        = r_we;
        n_lo_bit    = r_lo_bit;
        n_hi_bit    = r_hi_bit;
        n_res_flag  = r_res_flag;
        n_res_index = r_res_index;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = r_eval_addr;
        mem_wdata   = r_rd_data;
        rd_en       = 1'b0;

        if (i_cfg_valid) begin
            n_biu = i_cfg_data;
        end

        case (r_state)
            // clearing pass after reset
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end

            // take a request, answer at once or set up a scan
            S_IDLE: begin
                if (in_acc) begin
                    n_res_index = in_start_raw;
                    n_res_flag  = 1'b1;
                    n_res_err   = 1'b0;
                    n_ws        = in_start[BIT_SEL_W +: AW];
                    n_lo_bit    = in_start[BIT_SEL_W-1:0];
                    n_we        = end_m1[BIT_SEL_W +: AW];
                    n_hi_bit    = end_m1[BIT_SEL_W-1:0];
                    n_rd_addr   = in_start[BIT_SEL_W +: AW];
                    n_issue     = 1'b1;
                    n_state     = S_SCAN;
                    case (in_cmd)
                        CMD_FIND:    n_mode = MODE_FIND;
                        CMD_MARK:    n_mode = MODE_SET;
                        CMD_RELEASE: n_mode = MODE_CLR;
                        default:     n_mode = MODE_CHECK;
                    endcase
                    if (in_cmd > CMD_TEST) begin
                        n_state = S_DONE;
                    end else if (bad) begin
                        n_res_err  = 1'b1;
                        n_res_flag = (in_cmd == CMD_MARK) || (in_cmd == CMD_RELEASE);
                        n_state    = S_DONE;
                    end else if (in_cmd == CMD_RELEASE && rel_end == in_start) begin
                        n_state = S_DONE;
                    end else if (in_cmd == CMD_CHECK && in_count == '0) begin
                        n_state = S_DONE;
                    end else if (in_cmd == CMD_CHECK && run_end > limit) begin
                        n_res_flag = 1'b0;
                        n_state    = S_DONE;
                    end
                    if (n_state == S_DONE) begin
                        n_issue = 1'b0;
                    end
                end
            end

            // stream reads one word a cycle; evaluate the word read last cycle
            S_SCAN: begin
                if (r_issue) begin
                    rd_en       = 1'b1;
                    n_eval      = 1'b1;
                    n_eval_addr = r_rd_addr;
                    if (r_rd_addr == r_we) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_addr = r_rd_addr + AW'(1);
                    end
                end
                if (r_eval) begin
                    case (r_mode)
                        MODE_FIND: begin
                            if (free_hits != '0) begin
                                n_res_flag  = 1'b1;
                                n_res_index = START_W'({r_eval_addr, hit_pos});
                                n_state     = S_DONE;
                            end else if (last_word) begin
                                n_res_flag = 1'b0;
                                n_state    = S_DONE;
                            end
                        end
                        MODE_CHECK: begin
                            if (used_hits != '0) begin
                                n_res_flag = 1'b0;
                                n_state    = S_DONE;
                            end else if (last_word) begin
                                n_state = S_DONE;
                            end
                        end
                        MODE_SET: begin
                            mem_we    = 1'b1;
                            mem_wdata = r_rd_data | run_mask;
                            if (last_word) begin
                                n_state = S_DONE;
                            end
                        end
                        MODE_CLR: begin
                            mem_we    = 1'b1;
                            mem_wdata = r_rd_data & ~run_mask;
                            if (last_word) begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                    if (n_state == S_DONE) begin
                        n_issue = 1'b0;
                        n_eval  = 1'b0;
                        rd_en   = 1'b0;
                    end
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0000, r_res_err, r_res_index, r_res_flag};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_biu       <= BIU_RESET;
            r_clr_addr  <= '0;
            r_issue     <= 1'b0;
            r_eval      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_biu       <= n_biu;
            r_clr_addr  <= n_clr_addr;
            r_issue     <= n_issue;
            r_eval      <= n_eval;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_rd_addr   <= n_rd_addr;
        r_eval_addr <= n_eval_addr;
        r_ws        <= n_ws;
        r_we        <= n_we;
        r_lo_bit    <= n_lo_bit;
        r_hi_bit    <= n_hi_bit;
        r_res_flag  <= n_res_flag;
        r_res_index <= n_res_index;
        r_res_err   <= n_res_err;
        r_out_data  <= n_out_data;
    end

    // Map RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_map[r_rd_addr];
        end
    end

`ifndef SYNTHESIS
    // A write-back never lands on the word being read in the same cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && rd_en) |-> (mem_waddr != r_rd_addr))
        else $error("map RAM read and write to the same word");

    // Evaluated data always comes from a read issued the cycle before
    a_eval_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eval |-> $past(rd_en))
        else $error("word evaluated without a preceding read");

    // A finished scan leaves no read in flight
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_issue && !r_eval))
        else $error("scan still active after result");

    // No request is taken until the clearing pass has finished
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !($past(in_acc)))
        else $error("request accepted during clearing pass");
`endif

endmodule

`default_nettype wire
